### rtl/look_at_view_matrix_assert.svh
// Assertion macros for the view matrix RTL.
`ifndef LOOK_AT_VIEW_MATRIX_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_ASSERT_SVH
`ifndef SYNTHESIS
`define LAV_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define LAV_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LAV_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define LAV_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

### rtl/lav_pkg.sv
package lav_pkg;
    localparam int UNIT_BITS     = 30;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DW            = 32;
    localparam int DIR_W         = 33;
    localparam int ACC_W         = 64;

    typedef logic signed [DW-1:0]    fix_t;
    typedef logic signed [DIR_W-1:0] dir_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    // One queued job: eye point, target minus eye, and the raw up vector.
    typedef struct packed {
        fix_t [2:0] eye;
        dir_t [2:0] dir;
        fix_t [2:0] upv;
    } item_t;

    // Unit vectors are Q30; dot[0..2] are eye.look, eye.right, eye.up.
    typedef struct packed {
        fix_t [2:0] look;
        fix_t [2:0] right;
        fix_t [2:0] up;
        acc_t [2:0] dot;
        logic       degen;
    } matrix_t;
endpackage

### rtl/look_at_view_matrix.sv
// Look-at view matrix generator.
// Input channel (s_valid/s_ready): one beat carries eye, target and up vectors,
// each component signed fixed point with FRAC_BITS fraction bits.
// Output channel (m_valid/m_ready): four beats per input, rows 0 to 3 in order;
// m_last_row marks row 3 and m_degenerate is set on all four rows when any
// vector to be normalized had zero length.
// A two-entry input queue takes beats while the compute engine is busy, and a
// row buffer holds the finished matrix so the engine can start the next job.
// The compute engine works on one job at a time: three normalizations each
// run a 32-step square root and a 31-step divide, and all products go
// through one 32x32 multiplier. Each vector is first rescaled by shifts
// until its largest component lies in [2^29, 2^30), and a zero-length
// vector skips the square root and divide.
// Reset (synchronous, aresetn low) empties the queue and the row buffer.
// When the receiver stalls, the current row holds; the engine finishes its job
// and waits, and the queue fills and then drops s_ready.
`include "look_at_view_matrix_assert.svh"
module look_at_view_matrix #(
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  lav_pkg::fix_t  s_eye_x,
    input  lav_pkg::fix_t  s_eye_y,
    input  lav_pkg::fix_t  s_eye_z,
    input  lav_pkg::fix_t  s_target_x,
    input  lav_pkg::fix_t  s_target_y,
    input  lav_pkg::fix_t  s_target_z,
    input  lav_pkg::fix_t  s_upvec_x,
    input  lav_pkg::fix_t  s_upvec_y,
    input  lav_pkg::fix_t  s_upvec_z,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [1:0]     m_row_index,
    output lav_pkg::fix_t  m_col0,
    output lav_pkg::fix_t  m_col1,
    output lav_pkg::fix_t  m_col2,
    output lav_pkg::fix_t  m_col3,
    output logic           m_degenerate,
    output logic           m_last_row
);
    import lav_pkg::*;

    logic     q_valid, q_ready;
    item_t    q_item;
    logic     mat_valid, mat_ready;
    matrix_t  mat;

    lav_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_eye_x    (s_eye_x),
        .s_eye_y    (s_eye_y),
        .s_eye_z    (s_eye_z),
        .s_target_x (s_target_x),
        .s_target_y (s_target_y),
        .s_target_z (s_target_z),
        .s_upvec_x  (s_upvec_x),
        .s_upvec_y  (s_upvec_y),
        .s_upvec_z  (s_upvec_z),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item)
    );

    lav_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .mat_valid (mat_valid),
        .mat_ready (mat_ready),
        .mat       (mat)
    );

    lav_rows #(
        .FRAC_BITS (FRAC_BITS)
    ) u_rows (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .mat_valid    (mat_valid),
        .mat_ready    (mat_ready),
        .mat          (mat),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_row_index  (m_row_index),
        .m_col0       (m_col0),
        .m_col1       (m_col1),
        .m_col2       (m_col2),
        .m_col3       (m_col3),
        .m_degenerate (m_degenerate),
        .m_last_row   (m_last_row)
    );

    `LAV_ASSERT_IMP(a_last_row, aclk, aresetn, m_valid, m_last_row == (m_row_index == 2'd3), "last_row flag disagrees with row index")
    `LAV_ASSERT_NXT(a_row_seq, aclk, aresetn, m_valid && m_ready && !m_last_row, m_valid && (m_row_index == $past(m_row_index) + 2'd1), "rows of one matrix not consecutive")
    `LAV_ASSERT_NXT(a_degen_hold, aclk, aresetn, m_valid && m_ready && !m_last_row, m_degenerate == $past(m_degenerate), "degenerate flag changed inside a matrix")
    `LAV_ASSERT_IMP(a_core_excl, aclk, aresetn, mat_valid, !q_ready, "engine takes a job while holding a result")
endmodule

### rtl/lav_front.sv
module lav_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  lav_pkg::fix_t   s_eye_x,
    input  lav_pkg::fix_t   s_eye_y,
    input  lav_pkg::fix_t   s_eye_z,
    input  lav_pkg::fix_t   s_target_x,
    input  lav_pkg::fix_t   s_target_y,
    input  lav_pkg::fix_t   s_target_z,
    input  lav_pkg::fix_t   s_upvec_x,
    input  lav_pkg::fix_t   s_upvec_y,
    input  lav_pkg::fix_t   s_upvec_z,
    output logic            q_valid,
    input  logic            q_ready,
    output lav_pkg::item_t  q_item
);
    import lav_pkg::*;

    localparam int QDEPTH = 2;

    item_t       in_item;
    item_t       mem_reg [QDEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push, pop;

    // The direction is formed here so the back end starts on it directly.
    always_comb begin
        in_item.eye[0] = s_eye_x;
        in_item.eye[1] = s_eye_y;
        in_item.eye[2] = s_eye_z;
        in_item.upv[0] = s_upvec_x;
        in_item.upv[1] = s_upvec_y;
        in_item.upv[2] = s_upvec_z;
        in_item.dir[0] = {s_target_x[DW-1], s_target_x} - {s_eye_x[DW-1], s_eye_x};
        in_item.dir[1] = {s_target_y[DW-1], s_target_y} - {s_eye_y[DW-1], s_eye_y};
        in_item.dir[2] = {s_target_z[DW-1], s_target_z} - {s_eye_z[DW-1], s_eye_z};
    end

    assign s_ready = (count_reg != 2'(QDEPTH));
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end
endmodule

### rtl/lav_core.sv
module lav_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  lav_pkg::item_t    q_item,
    output logic              mat_valid,
    input  logic              mat_ready,
    output lav_pkg::matrix_t  mat
);
    import lav_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ABS   = 4'd1;
    localparam logic [3:0] ST_SCALE = 4'd2;
    localparam logic [3:0] ST_MAC   = 4'd3;
    localparam logic [3:0] ST_SQRT  = 4'd4;
    localparam logic [3:0] ST_DINIT = 4'd5;
    localparam logic [3:0] ST_DIV   = 4'd6;
    localparam logic [3:0] ST_NEXT  = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    localparam logic [1:0] SEL_LOOK  = 2'd0;
    localparam logic [1:0] SEL_UPSC  = 2'd1;
    localparam logic [1:0] SEL_RIGHT = 2'd2;
    localparam logic [1:0] SEL_UP    = 2'd3;

    localparam logic [1:0] KIND_SQ     = 2'd0;
    localparam logic [1:0] KIND_CROSS1 = 2'd1;
    localparam logic [1:0] KIND_CROSS2 = 2'd2;
    localparam logic [1:0] KIND_DOT    = 2'd3;

    localparam int VIN_W      = 63;
    localparam int MAG_W      = VIN_W - 1;
    localparam int SQ_W       = 64;
    localparam int LEN_W      = UNIT_BITS + 1;
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int DIV_STEPS  = UNIT_BITS;
    localparam int CNT_W      = 5;

    localparam logic [MAG_W-1:0] LIM_R8 = MAG_W'(1) << (UNIT_BITS + 7);
    localparam logic [MAG_W-1:0] LIM_R1 = MAG_W'(1) << UNIT_BITS;
    localparam logic [MAG_W-1:0] LIM_L8 = MAG_W'(1) << (UNIT_BITS - 8);
    localparam logic [MAG_W-1:0] LIM_L1 = MAG_W'(1) << (UNIT_BITS - 1);

    function automatic logic [1:0] next3(input logic [1:0] i);
        next3 = (i == 2'd2) ? 2'd0 : i + 2'd1;
    endfunction

    logic [3:0]               state_reg, state_next;
    logic [1:0]               sel_reg, sel_next;
    logic [1:0]               kind_reg, kind_next;
    logic [1:0]               grp_reg, grp_next;
    logic [1:0]               idx_reg, idx_next;
    logic                     ph_reg, ph_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     degen_reg, degen_next;

    fix_t                     eye_reg [3], eye_next [3];
    fix_t                     upv_reg [3], upv_next [3];
    logic signed [VIN_W-1:0]  vin_reg [3], vin_next [3];
    logic [MAG_W-1:0]         mag_reg [3], mag_next [3];
    logic                     neg_reg [3], neg_next [3];
    fix_t                     upsc_reg [3], upsc_next [3];
    fix_t                     look_reg [3], look_next [3];
    fix_t                     right_reg [3], right_next [3];
    fix_t                     up_reg [3], up_next [3];
    acc_t                     dot_reg [3], dot_next [3];
    acc_t                     prod_reg, prod_next;
    acc_t                     acc_reg, acc_next;
    logic [SQ_W-1:0]          sqx_reg, sqx_next;
    logic [SQ_W-1:0]          sqr_reg, sqr_next;
    logic [SQ_W-1:0]          sqb_reg, sqb_next;
    logic [LEN_W-1:0]         len_reg, len_next;
    logic [LEN_W-1:0]         rem_reg [3], rem_next [3];
    logic [LEN_W-1:0]         quo_reg [3], quo_next [3];

    fix_t                     opa, opb;
    acc_t                     mul_full;
    logic [1:0]               ia, ib, last_idx, last_grp;
    logic                     sub;

    // Operand selection for the shared multiplier.
    always_comb begin
        opa      = '0;
        opb      = '0;
        last_idx = 2'd2;
        last_grp = 2'd2;
        sub      = 1'b0;
        ia       = idx_reg[0] ? next3(next3(grp_reg)) : next3(grp_reg);
        ib       = idx_reg[0] ? next3(grp_reg) : next3(next3(grp_reg));
        case (kind_reg)
            KIND_SQ: begin
                opa      = {2'b00, mag_reg[idx_reg][UNIT_BITS-1:0]};
                opb      = {2'b00, mag_reg[idx_reg][UNIT_BITS-1:0]};
                last_grp = 2'd0;
            end
            KIND_CROSS1: begin
                opa      = upsc_reg[ia];
                opb      = look_reg[ib];
                last_idx = 2'd1;
                sub      = idx_reg[0];
            end
            KIND_CROSS2: begin
                opa      = look_reg[ia];
                opb      = right_reg[ib];
                last_idx = 2'd1;
                sub      = idx_reg[0];
            end
            KIND_DOT: begin
                opa = eye_reg[idx_reg];
                case (grp_reg)
                    2'd0:    opb = look_reg[idx_reg];
                    2'd1:    opb = right_reg[idx_reg];
                    default: opb = up_reg[idx_reg];
                endcase
            end
            default: begin
                opa = '0;
            end
        endcase
    end

    assign mul_full = opa * opb;

    always_comb begin
        logic                    allzero;
        logic [MAG_W-1:0]        m01;
        logic [MAG_W-1:0]        mmax;
        acc_t                    base;
        acc_t                    sum;
        logic [SQ_W-1:0]         sq_t;
        logic [SQ_W-1:0]         sqr_n;
        logic [LEN_W:0]          rem2;
        logic                    ge;
        logic                    flip;
        logic [DW-1:0]           uval;
        logic [DW-1:0]           mz;
        logic [VIN_W-1:0]        vabs;

        state_next = state_reg;
        sel_next   = sel_reg;
        kind_next  = kind_reg;
        grp_next   = grp_reg;
        idx_next   = idx_reg;
        ph_next    = ph_reg;
        cnt_next   = cnt_reg;
        degen_next = degen_reg;
        eye_next   = eye_reg;
        upv_next   = upv_reg;
        vin_next   = vin_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        upsc_next  = upsc_reg;
        look_next  = look_reg;
        right_next = right_reg;
        up_next    = up_reg;
        dot_next   = dot_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        sqx_next   = sqx_reg;
        sqr_next   = sqr_reg;
        sqb_next   = sqb_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;

        allzero = (vin_reg[0] == '0) && (vin_reg[1] == '0) && (vin_reg[2] == '0);
        m01     = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
        mmax    = (m01 > mag_reg[2]) ? m01 : mag_reg[2];
        base    = (idx_reg == 2'd0) ? '0 : acc_reg;
        sum     = sub ? (base - prod_reg) : (base + prod_reg);
        sq_t    = sqr_reg + sqb_reg;
        sqr_n   = '0;
        rem2    = '0;
        ge      = 1'b0;
        flip    = (sel_reg == SEL_LOOK);
        uval    = '0;
        mz      = '0;
        vabs    = '0;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    for (int i = 0; i < 3; i++) begin
                        eye_next[i] = q_item.eye[i];
                        upv_next[i] = q_item.upv[i];
                        vin_next[i] = VIN_W'($signed(q_item.dir[i]));
                    end
                    sel_next   = SEL_LOOK;
                    degen_next = 1'b0;
                    state_next = ST_ABS;
                end
            end
            ST_ABS: begin
                for (int i = 0; i < 3; i++) begin
                    vabs        = vin_reg[i][VIN_W-1] ? (~vin_reg[i] + 1'b1) : vin_reg[i];
                    neg_next[i] = vin_reg[i][VIN_W-1];
                    mag_next[i] = vabs[MAG_W-1:0];
                end
                if (allzero) begin
                    // A zero vector normalizes to zero and, unless it is the raw up vector, marks the matrix.
                    for (int i = 0; i < 3; i++) begin
                        case (sel_reg)
                            SEL_UPSC:  upsc_next[i]  = '0;
                            SEL_LOOK:  look_next[i]  = '0;
                            SEL_RIGHT: right_next[i] = '0;
                            default:   up_next[i]    = '0;
                        endcase
                    end
                    if (sel_reg != SEL_UPSC) begin
                        degen_next = 1'b1;
                    end
                    state_next = ST_NEXT;
                end else begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (mmax >= LIM_R8) begin
                    for (int i = 0; i < 3; i++) mag_next[i] = mag_reg[i] >> 8;
                end else if (mmax >= LIM_R1) begin
                    for (int i = 0; i < 3; i++) mag_next[i] = mag_reg[i] >> 1;
                end else if (mmax < LIM_L8) begin
                    for (int i = 0; i < 3; i++) mag_next[i] = mag_reg[i] << 8;
                end else if (mmax < LIM_L1) begin
                    for (int i = 0; i < 3; i++) mag_next[i] = mag_reg[i] << 1;
                end else if (sel_reg == SEL_UPSC) begin
                    for (int i = 0; i < 3; i++) begin
                        mz           = {2'b00, mag_reg[i][UNIT_BITS-1:0]};
                        upsc_next[i] = neg_reg[i] ? (~mz + 1'b1) : mz;
                    end
                    state_next = ST_NEXT;
                end else begin
                    kind_next  = KIND_SQ;
                    grp_next   = 2'd0;
                    idx_next   = 2'd0;
                    ph_next    = 1'b0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                if (!ph_reg) begin
                    prod_next = mul_full;
                    ph_next   = 1'b1;
                end else begin
                    acc_next = sum;
                    ph_next  = 1'b0;
                    if (idx_reg == last_idx) begin
                        case (kind_reg)
                            KIND_SQ: begin
                                sqx_next = SQ_W'(sum);
                                sqr_next = '0;
                                sqb_next = SQ_W'(1) << (SQ_W - 2);
                                cnt_next = '0;
                            end
                            KIND_DOT: dot_next[grp_reg] = sum;
                            default:  vin_next[grp_reg] = sum[VIN_W-1:0];
                        endcase
                        idx_next = 2'd0;
                        if (grp_reg == last_grp) begin
                            case (kind_reg)
                                KIND_SQ:     state_next = ST_SQRT;
                                KIND_CROSS1: begin
                                    sel_next   = SEL_RIGHT;
                                    state_next = ST_ABS;
                                end
                                KIND_CROSS2: begin
                                    sel_next   = SEL_UP;
                                    state_next = ST_ABS;
                                end
                                default:     state_next = ST_DONE;
                            endcase
                        end else begin
                            grp_next = grp_reg + 2'd1;
                        end
                    end else begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end
            ST_SQRT: begin
                // One result bit of the integer square root per cycle.
                if (sqx_reg >= sq_t) begin
                    sqx_next = sqx_reg - sq_t;
                    sqr_n    = (sqr_reg >> 1) + sqb_reg;
                end else begin
                    sqr_n = sqr_reg >> 1;
                end
                sqr_next = sqr_n;
                sqb_next = sqb_reg >> 2;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1)) begin
                    len_next   = sqr_n[LEN_W-1:0];
                    state_next = ST_DINIT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DINIT: begin
                for (int i = 0; i < 3; i++) begin
                    ge          = ({1'b0, mag_reg[i][UNIT_BITS-1:0]} >= len_reg);
                    rem_next[i] = ge ? ({1'b0, mag_reg[i][UNIT_BITS-1:0]} - len_reg)
                                     : {1'b0, mag_reg[i][UNIT_BITS-1:0]};
                    quo_next[i] = {{(LEN_W-1){1'b0}}, ge};
                end
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                // Three restoring dividers share the length as divisor.
                for (int i = 0; i < 3; i++) begin
                    rem2        = {rem_reg[i], 1'b0};
                    ge          = (rem2 >= {1'b0, len_reg});
                    rem_next[i] = ge ? LEN_W'(rem2 - {1'b0, len_reg}) : rem2[LEN_W-1:0];
                    quo_next[i] = {quo_reg[i][LEN_W-2:0], ge};
                    uval        = {1'b0, quo_next[i]};
                    if (neg_reg[i] ^ flip) begin
                        uval = ~uval + 1'b1;
                    end
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                        case (sel_reg)
                            SEL_LOOK:  look_next[i]  = uval;
                            SEL_RIGHT: right_next[i] = uval;
                            default:   up_next[i]    = uval;
                        endcase
                    end
                end
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_NEXT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_NEXT: begin
                grp_next = 2'd0;
                idx_next = 2'd0;
                ph_next  = 1'b0;
                case (sel_reg)
                    SEL_LOOK: begin
                        for (int i = 0; i < 3; i++) begin
                            vin_next[i] = VIN_W'(upv_reg[i]);
                        end
                        sel_next   = SEL_UPSC;
                        state_next = ST_ABS;
                    end
                    SEL_UPSC: begin
                        kind_next  = KIND_CROSS1;
                        state_next = ST_MAC;
                    end
                    SEL_RIGHT: begin
                        kind_next  = KIND_CROSS2;
                        state_next = ST_MAC;
                    end
                    default: begin
                        kind_next  = KIND_DOT;
                        state_next = ST_MAC;
                    end
                endcase
            end
            ST_DONE: begin
                if (mat_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sel_reg   <= SEL_LOOK;
            kind_reg  <= KIND_SQ;
            grp_reg   <= 2'd0;
            idx_reg   <= 2'd0;
            ph_reg    <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            kind_reg  <= kind_next;
            grp_reg   <= grp_next;
            idx_reg   <= idx_next;
            ph_reg    <= ph_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        degen_reg <= degen_next;
        eye_reg   <= eye_next;
        upv_reg   <= upv_next;
        vin_reg   <= vin_next;
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        upsc_reg  <= upsc_next;
        look_reg  <= look_next;
        right_reg <= right_next;
        up_reg    <= up_next;
        dot_reg   <= dot_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        sqx_reg   <= sqx_next;
        sqr_reg   <= sqr_next;
        sqb_reg   <= sqb_next;
        len_reg   <= len_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
    end

    assign q_ready   = (state_reg == ST_IDLE);
    assign mat_valid = (state_reg == ST_DONE);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mat.look[i]  = look_reg[i];
            mat.right[i] = right_reg[i];
            mat.up[i]    = up_reg[i];
            mat.dot[i]   = dot_reg[i];
        end
        mat.degen = degen_reg;
    end
endmodule

### rtl/lav_rows.sv
module lav_rows #(
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              mat_valid,
    output logic              mat_ready,
    input  lav_pkg::matrix_t  mat,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_row_index,
    output lav_pkg::fix_t     m_col0,
    output lav_pkg::fix_t     m_col1,
    output lav_pkg::fix_t     m_col2,
    output lav_pkg::fix_t     m_col3,
    output logic              m_degenerate,
    output logic              m_last_row
);
    import lav_pkg::*;

    localparam int        SH      = UNIT_BITS - FRAC_BITS;
    localparam logic [1:0] ROW_LAST = 2'd3;
    localparam fix_t      ONE_FIX = fix_t'(1) << FRAC_BITS;

    // Q30 to the output format, truncating toward zero.
    function automatic fix_t unit_to_fix(input fix_t q);
        logic [DW-1:0] a;
        logic [DW-1:0] m;
        a = q[DW-1] ? (~q + 1'b1) : q;
        m = a >> SH;
        unit_to_fix = q[DW-1] ? (~m + 1'b1) : m;
    endfunction

    // Negated dot product scaled down by 2^30, truncated toward zero, saturated.
    function automatic fix_t neg_dot(input acc_t s);
        logic [ACC_W-1:0]          a;
        logic [ACC_W-UNIT_BITS-1:0] m;
        a = s[ACC_W-1] ? (~s + 1'b1) : s;
        m = a[ACC_W-1:UNIT_BITS];
        if (s[ACC_W-1]) begin
            neg_dot = (m > (ACC_W-UNIT_BITS)'(32'h7FFF_FFFF)) ? fix_t'(32'h7FFF_FFFF)
                                                             : fix_t'(m[DW-1:0]);
        end else begin
            neg_dot = (m > (ACC_W-UNIT_BITS)'(32'h8000_0000)) ? fix_t'(32'h8000_0000)
                                                             : fix_t'(~m[DW-1:0] + 1'b1);
        end
    endfunction

    logic        busy_reg, busy_next;
    logic [1:0]  row_reg, row_next;
    logic        degen_reg;
    fix_t        ent_reg [4][3];
    logic        load, beat;

    assign beat      = busy_reg && m_ready;
    assign mat_ready = !busy_reg || (m_ready && (row_reg == ROW_LAST));
    assign load      = mat_valid && mat_ready;

    always_comb begin
        busy_next = busy_reg;
        row_next  = row_reg;
        if (beat) begin
            if (row_reg == ROW_LAST) begin
                busy_next = 1'b0;
                row_next  = 2'd0;
            end else begin
                row_next = row_reg + 2'd1;
            end
        end
        if (load) begin
            busy_next = 1'b1;
            row_next  = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            row_reg  <= 2'd0;
        end else begin
            busy_reg <= busy_next;
            row_reg  <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int k = 0; k < 3; k++) begin
                ent_reg[k][0] <= unit_to_fix(mat.right[k]);
                ent_reg[k][1] <= unit_to_fix(mat.up[k]);
                ent_reg[k][2] <= unit_to_fix(mat.look[k]);
            end
            ent_reg[3][0] <= neg_dot(mat.dot[1]);
            ent_reg[3][1] <= neg_dot(mat.dot[2]);
            ent_reg[3][2] <= neg_dot(mat.dot[0]);
            degen_reg     <= mat.degen;
        end
    end

    assign m_valid      = busy_reg;
    assign m_row_index  = row_reg;
    assign m_col0       = ent_reg[row_reg][0];
    assign m_col1       = ent_reg[row_reg][1];
    assign m_col2       = ent_reg[row_reg][2];
    assign m_col3       = (row_reg == ROW_LAST) ? ONE_FIX : '0;
    assign m_degenerate = degen_reg;
    assign m_last_row   = (row_reg == ROW_LAST);
endmodule

### bench/look_at_view_matrix_tb.sv
`timescale 1ns / 100ps

module look_at_view_matrix_tb;
    import lav_pkg::*;

    localparam int FRAC      = FRAC_BITS_DEF;
    localparam int Q_BITS    = 30;
    localparam int N_RANDOM  = 210;
    localparam int HOLD_LEN  = 1500;
    localparam int SETTLE    = 400;
    localparam int WDOG_MAX  = 20000;

    typedef enum logic [1:0] {ROWS_PREDICTED, ROWS_ZERO, ROWS_IDENTITY} row_src_t;
    typedef longint vec3_t [3];

    typedef struct {
        logic [1:0] idx;
        fix_t       c0, c1, c2, c3;
        logic       degen;
        logic       last;
    } view_row_t;

    typedef struct {
        fix_t     v [9];
        row_src_t src;
    } camera_stim_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    fix_t s_in [9];
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_row_index;
    fix_t m_col0, m_col1, m_col2, m_col3;
    logic m_degenerate, m_last_row;

    view_row_t pending_rows[$];
    int errors = 0;
    int beats_in = 0;
    int rows_out = 0;
    int degen_rows = 0;
    bit quiet = 1'b0;

    always #1 aclk = ~aclk;

    look_at_view_matrix i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_eye_x(s_in[0]), .s_eye_y(s_in[1]), .s_eye_z(s_in[2]),
        .s_target_x(s_in[3]), .s_target_y(s_in[4]), .s_target_z(s_in[5]),
        .s_upvec_x(s_in[6]), .s_upvec_y(s_in[7]), .s_upvec_z(s_in[8]),
        .m_valid(m_valid), .m_ready(m_ready), .m_row_index(m_row_index),
        .m_col0(m_col0), .m_col1(m_col1), .m_col2(m_col2), .m_col3(m_col3),
        .m_degenerate(m_degenerate), .m_last_row(m_last_row)
    );

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Shifts all three magnitudes alike until the largest sits in [2^29, 2^30).
    function automatic bit block_scale(input vec3_t v, output longint unsigned mag [3],
                                       output bit neg [3]);
        longint unsigned m;
        m = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? -v[i] : v[i];
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) return 1'b1;
        while (m >= (64'd1 << Q_BITS)) begin
            m >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        while (m < (64'd1 << (Q_BITS - 1))) begin
            m <<= 1;
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
        end
        return 1'b0;
    endfunction

    function automatic bit unit_vec(input vec3_t v, output vec3_t u);
        longint unsigned mag [3];
        bit neg [3];
        longint unsigned len, q;
        u = '{0, 0, 0};
        if (block_scale(v, mag, neg)) return 1'b1;
        len = int_sqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
        for (int i = 0; i < 3; i++) begin
            q = (mag[i] << Q_BITS) / len;
            u[i] = neg[i] ? -longint'(q) : longint'(q);
        end
        return 1'b0;
    endfunction

    function automatic vec3_t cross3(input vec3_t a, input vec3_t b);
        vec3_t c;
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
        return c;
    endfunction

    function automatic fix_t q30_to_fix(input longint q);
        longint unsigned m;
        m = (q < 0 ? -q : q) >> (Q_BITS - FRAC);
        return fix_t'(q < 0 ? -longint'(m) : longint'(m));
    endfunction

    function automatic fix_t eye_offset(input vec3_t eye, input vec3_t u);
        longint r;
        r = -(eye[0] * u[0] + eye[1] * u[1] + eye[2] * u[2]) / (64'sd1 <<< Q_BITS);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return fix_t'(r);
    endfunction

    task automatic predict_view(input fix_t v [9]);
        vec3_t eye, dir, upin, upsc, look, right, up;
        longint unsigned mag [3];
        bit neg [3];
        bit degen;
        view_row_t row;
        for (int i = 0; i < 3; i++) begin
            eye[i]  = longint'(v[i]);
            dir[i]  = longint'(v[3 + i]) - eye[i];
            upin[i] = longint'(v[6 + i]);
        end
        degen = unit_vec(dir, look);
        for (int i = 0; i < 3; i++) look[i] = -look[i];
        void'(block_scale(upin, mag, neg));
        for (int i = 0; i < 3; i++) upsc[i] = neg[i] ? -longint'(mag[i]) : longint'(mag[i]);
        degen |= unit_vec(cross3(upsc, look), right);
        degen |= unit_vec(cross3(look, right), up);
        for (int k = 0; k < 3; k++) begin
            row = '{idx: 2'(k), c0: q30_to_fix(right[k]), c1: q30_to_fix(up[k]),
                    c2: q30_to_fix(look[k]), c3: '0, degen: degen, last: 1'b0};
            pending_rows.push_back(row);
        end
        row = '{idx: 2'd3, c0: eye_offset(eye, right), c1: eye_offset(eye, up),
                c2: eye_offset(eye, look), c3: fix_t'(1 << FRAC), degen: degen, last: 1'b1};
        pending_rows.push_back(row);
    endtask

    // Matrices that can be written down directly: the degenerate one, zero but for the one in row 3, and identity.
    task automatic push_known(input row_src_t src);
        view_row_t row;
        for (int k = 0; k < 4; k++) begin
            row = '{idx: 2'(k), c0: '0, c1: '0, c2: '0, c3: '0,
                    degen: src == ROWS_ZERO, last: k == 3};
            if (k == 3) row.c3 = fix_t'(1 << FRAC);
            if (src == ROWS_IDENTITY && k == 0) row.c0 = fix_t'(1 << FRAC);
            if (src == ROWS_IDENTITY && k == 1) row.c1 = fix_t'(1 << FRAC);
            if (src == ROWS_IDENTITY && k == 2) row.c2 = fix_t'(1 << FRAC);
            pending_rows.push_back(row);
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic fix_t rand_small();
        return fix_t'($signed($urandom_range(0, 2 * 1048576)) - 1048576);
    endfunction

    function automatic camera_stim_t random_camera();
        camera_stim_t c;
        int mode;
        int sh;
        mode = $urandom_range(0, 9);
        c.src = ROWS_PREDICTED;
        for (int i = 0; i < 9; i++) c.v[i] = (mode < 5) ? fix_t'($urandom) : rand_small();
        if (mode == 7) begin
            for (int i = 0; i < 3; i++) c.v[3 + i] = c.v[i];
        end else if (mode == 8) begin
            // Up parallel to the view direction leaves no right vector.
            sh = $urandom_range(0, 8);
            for (int i = 0; i < 3; i++) c.v[6 + i] = (c.v[3 + i] - c.v[i]) <<< sh;
        end else if (mode == 9) begin
            for (int i = 6; i < 9; i++) c.v[i] = '0;
        end
        return c;
    endfunction

    camera_stim_t directed_tbl [11];

    initial begin
        for (int i = 0; i < 9; i++) s_in[i] = '0;
        directed_tbl = '{
            '{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, ROWS_ZERO},
            '{'{0, 0, 0, 0, 0, -65536, 0, 65536, 0}, ROWS_IDENTITY},
            '{'{65536, 131072, -65536, 65536, 131072, -65536, 0, 65536, 0}, ROWS_PREDICTED},
            '{'{0, 0, 0, 65536, 65536, 0, 0, 0, 0}, ROWS_PREDICTED},
            '{'{0, 0, 0, 0, 65536, 0, 0, 65536, 0}, ROWS_PREDICTED},
            '{'{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                32'h80000000, 0, 32'h7FFFFFFF, 0}, ROWS_PREDICTED},
            '{'{32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF}, ROWS_PREDICTED},
            '{'{32'h80000000, 0, 0, 32'h80000000, 0, -65536, 0, 65536, 0}, ROWS_PREDICTED},
            '{'{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 1, 0, 0}, ROWS_PREDICTED},
            '{'{-1, -1, -1, 1, 1, 1, -1, 1, -1}, ROWS_PREDICTED},
            '{'{32'h55555555, 32'hAAAAAAAA, 32'h0F0F0F0F, 32'hF0F0F0F0, 32'h33333333,
                32'hCCCCCCCC, 32'hFFFF0000, 32'h0000FFFF, 32'h7FFF8001}, ROWS_PREDICTED}
        };
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        for (int n = 0; n < $size(directed_tbl) + N_RANDOM; n++) begin
            camera_stim_t c;
            if (n < $size(directed_tbl)) c = directed_tbl[n];
            else c = random_camera();
            quiet = (n >= 100 && n < 150);
            if (!quiet && $urandom_range(0, 99) < 9) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
            end
            s_valid <= 1'b1;
            for (int i = 0; i < 9; i++) s_in[i] <= c.v[i];
            do @(posedge aclk); while (!s_ready);
            if (c.src == ROWS_PREDICTED) predict_view(c.v);
            else push_known(c.src);
            beats_in++;
            @(negedge aclk);
        end
        s_valid <= 1'b0;
        wait (pending_rows.size() == 0);
        repeat (SETTLE) @(posedge aclk);
        $display("%0d camera beats in, %0d matrix rows checked, %0d of them degenerate.",
                 beats_in, rows_out, degen_rows);
        $display("Covered field extremes, coincident eye and target, zero and parallel up.");
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Receiver: random stalls, one long hold-off once 60 camera beats are in.
    initial begin
        bit held;
        held = 1'b0;
        forever begin
            @(negedge aclk);
            if (!held && beats_in >= 60) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_LEN) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= quiet || ($urandom_range(0, 99) >= 9);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            view_row_t want;
            rows_out++;
            if (m_degenerate) degen_rows++;
            if (pending_rows.size() == 0) begin
                report_mismatch("unexpected row", longint'(m_row_index), -64'sd1);
            end else begin
                want = pending_rows.pop_front();
                if (m_row_index !== want.idx)
                    report_mismatch("row_index", longint'(m_row_index), longint'(want.idx));
                if (m_col0 !== want.c0)
                    report_mismatch("col0", longint'(m_col0), longint'(want.c0));
                if (m_col1 !== want.c1)
                    report_mismatch("col1", longint'(m_col1), longint'(want.c1));
                if (m_col2 !== want.c2)
                    report_mismatch("col2", longint'(m_col2), longint'(want.c2));
                if (m_col3 !== want.c3)
                    report_mismatch("col3", longint'(m_col3), longint'(want.c3));
                if (m_degenerate !== want.degen)
                    report_mismatch("degenerate", longint'(m_degenerate),
                                    longint'(want.degen));
                if (m_last_row !== want.last)
                    report_mismatch("last_row", longint'(m_last_row), longint'(want.last));
            end
        end
    end

    // Watchdog on cycles with no beat on either channel.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WDOG_MAX) begin
                $display("timeout with %0d rows still expected", pending_rows.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end
endmodule

### filelist.f
+incdir+rtl
rtl/lav_pkg.sv
rtl/lav_front.sv
rtl/lav_core.sv
rtl/lav_rows.sv
rtl/look_at_view_matrix.sv
bench/look_at_view_matrix_tb.sv
